/* hw/rtl/assert_macros.svh */
// assertion macros for the tokenizer rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("%m failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/jtok_pkg.sv */
// types, constants and the per-byte scan function of the json tokenizer
// no dependencies
package jtok_pkg;

  localparam int OB = 24;
  localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = 3;

  localparam logic [3:0] KIND_END    = 4'd0;
  localparam logic [3:0] KIND_ERROR  = 4'd1;
  localparam logic [3:0] KIND_TRUE   = 4'd2;
  localparam logic [3:0] KIND_FALSE  = 4'd3;
  localparam logic [3:0] KIND_NULL   = 4'd4;
  localparam logic [3:0] KIND_STRING = 4'd5;
  localparam logic [3:0] KIND_NUMBER = 4'd6;
  localparam logic [3:0] KIND_COMMA  = 4'd7;
  localparam logic [3:0] KIND_COLON  = 4'd8;
  localparam logic [3:0] KIND_LCURLY = 4'd9;
  localparam logic [3:0] KIND_RCURLY = 4'd10;
  localparam logic [3:0] KIND_LBRACK = 4'd11;
  localparam logic [3:0] KIND_RBRACK = 4'd12;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_KEYWORD, MODE_NUMBER, MODE_STRING
  } mode_t;

  localparam logic [2:0] NM_SIGN = 3'd0;
  localparam logic [2:0] NM_ZERO = 3'd1;
  localparam logic [2:0] NM_INT = 3'd2;
  localparam logic [2:0] NM_FRAC0 = 3'd3;
  localparam logic [2:0] NM_FRAC = 3'd4;
  localparam logic [2:0] NM_EXP0 = 3'd5;
  localparam logic [2:0] NM_EXPS = 3'd6;
  localparam logic [2:0] NM_EXP = 3'd7;

  localparam logic [2:0] ST_BODY = 3'd0;
  localparam logic [2:0] ST_ESC = 3'd1;
  localparam logic [2:0] ST_HEX = 3'd2;
  localparam logic [2:0] ST_UTF8 = 3'd3;

  localparam logic [1:0] NR_TAKEN = 2'd0;
  localparam logic [1:0] NR_DONE = 2'd1;
  localparam logic [1:0] NR_BAD = 2'd2;

  typedef struct packed {
    mode_t          mode;
    logic [2:0]     sub;
    logic [1:0]     kw_id;
    logic           kw_mm;
    logic [1:0]     u_rem;
    logic [2:0]     u_len;
    logic [20:0]    cp;
    logic [2:0]     hex_cnt;
    logic [OB-1:0]  tok_begin;
    logic [OB-1:0]  idx;
    logic           esc;
    logic           stopped;
  } scan_st_t;

  typedef struct packed {
    logic [3:0]     kind;
    logic [OB-1:0]  start;
    logic [OB:0]    len;
    logic           esc;
    logic           run_end;
  } tok_t;

  typedef struct packed {
    scan_st_t       s;
    logic [1:0]     n;
    tok_t [1:0]     tok;
  } feed_t;

  typedef struct packed {
    logic [1:0]     n;
    tok_t [2:0]     tok;
  } push_t;

  function automatic logic [7:0] kw_char(logic [1:0] id, logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (id)
      2'd0: ch = (pos == 3'd0) ? "t" : (pos == 3'd1) ? "r" : (pos == 3'd2) ? "u" :
                 (pos == 3'd3) ? "e" : 8'h00;
      2'd1: ch = (pos == 3'd0) ? "f" : (pos == 3'd1) ? "a" : (pos == 3'd2) ? "l" :
                 (pos == 3'd3) ? "s" : (pos == 3'd4) ? "e" : 8'h00;
      default: ch = (pos == 3'd0) ? "n" : (pos == 3'd1) ? "u" : (pos == 3'd2) ? "l" :
                    (pos == 3'd3) ? "l" : 8'h00;
    endcase
    return ch;
  endfunction

  function automatic feed_t emit_tok(feed_t r, logic [3:0] kind, logic [OB-1:0] start,
                                     logic [OB:0] len, logic esc);
    feed_t o;
    o = r;
    o.tok[r.n[0]].kind = kind;
    o.tok[r.n[0]].start = start;
    o.tok[r.n[0]].len = len;
    o.tok[r.n[0]].esc = esc;
    o.tok[r.n[0]].run_end = 1'b0;
    o.n = r.n + 2'd1;
    return o;
  endfunction

  function automatic feed_t fail_tok(feed_t r, logic [OB-1:0] len);
    feed_t o;
    o = emit_tok(r, KIND_ERROR, r.s.tok_begin, {1'b0, len}, 1'b0);
    o.s.stopped = 1'b1;
    o.s.mode = MODE_IDLE;
    return o;
  endfunction

  // one byte through the scanner, including the rescan of a byte that ends a token
  function automatic feed_t feed(scan_st_t s_in, logic [7:0] c, logic [OB-1:0] off);
    feed_t          r;
    logic           rescan;
    logic [OB-1:0]  len;
    logic [1:0]     id;
    logic [2:0]     klen;
    logic           mm;
    logic           dig;
    logic           ex;
    logic           alnum;
    logic           hexd;
    logic [1:0]     nr;
    logic [2:0]     ul;
    logic [20:0]    cpn;
    logic [OB-1:0]  lead;
    r = '0;
    r.s = s_in;
    rescan = 1'b0;
    len = off - s_in.tok_begin;
    dig = (c >= "0") && (c <= "9");
    ex = (c == "e") || (c == "E");
    alnum = dig || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    hexd = dig || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    id = s_in.kw_id;
    klen = (id == 2'd1) ? 3'd5 : 3'd4;
    mm = s_in.kw_mm || (id == 2'd3);
    nr = NR_TAKEN;
    ul = s_in.u_len - {1'b0, s_in.u_rem};
    lead = off - {{(OB-3){1'b0}}, ul};
    cpn = {s_in.cp[14:0], c[5:0]};
    if (!s_in.stopped) begin
      unique case (s_in.mode)
        MODE_SLASH: begin
          if (c == "/") r.s.mode = MODE_LINE;
          else if (c == "*") begin
            r.s.mode = MODE_BLOCK;
            r.s.sub = 3'd0;
          end else r = fail_tok(r, OB'(1));
        end
        MODE_LINE: begin
          if (c == 8'h00 || c == 8'h0D || c == 8'h0A) begin
            r.s.mode = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_BLOCK: begin
          if (c == 8'h00) r = fail_tok(r, OB'(1));
          else if (s_in.sub == 3'd1 && c == "/") r.s.mode = MODE_IDLE;
          else r.s.sub = (c == "*") ? 3'd1 : 3'd0;
        end
        MODE_KEYWORD: begin
          if (alnum) begin
            if (len >= OB'(klen) || kw_char(id, len[2:0]) != c) mm = 1'b1;
            r.s.kw_mm = mm;
          end else if (!mm && len == OB'(klen)) begin
            r = emit_tok(r, (id == 2'd0) ? KIND_TRUE : (id == 2'd1) ? KIND_FALSE : KIND_NULL,
                         s_in.tok_begin, {1'b0, len}, 1'b0);
            r.s.mode = MODE_IDLE;
            rescan = 1'b1;
          end else r = fail_tok(r, len);
        end
        MODE_NUMBER: begin
          unique case (s_in.sub)
            NM_SIGN: begin
              if (c == "0") r.s.sub = NM_ZERO;
              else if (dig) r.s.sub = NM_INT;
              else nr = NR_BAD;
            end
            NM_ZERO, NM_INT: begin
              if (dig) nr = (s_in.sub == NM_ZERO) ? NR_BAD : NR_TAKEN;
              else if (c == ".") r.s.sub = NM_FRAC0;
              else if (ex) r.s.sub = NM_EXP0;
              else nr = NR_DONE;
            end
            NM_FRAC0: begin
              if (!dig) nr = NR_BAD;
              else r.s.sub = NM_FRAC;
            end
            NM_FRAC: begin
              if (ex) r.s.sub = NM_EXP0;
              else if (!dig) nr = NR_DONE;
            end
            NM_EXP0: begin
              if (c == "+" || c == "-") r.s.sub = NM_EXPS;
              else if (dig) r.s.sub = NM_EXP;
              else nr = NR_BAD;
            end
            NM_EXPS: begin
              if (!dig) nr = NR_BAD;
              else r.s.sub = NM_EXP;
            end
            default: nr = dig ? NR_TAKEN : NR_DONE;
          endcase
          if (nr == NR_BAD) r = fail_tok(r, len);
          else if (nr == NR_DONE) begin
            r = emit_tok(r, KIND_NUMBER, s_in.tok_begin, {1'b0, len}, 1'b0);
            r.s.mode = MODE_IDLE;
            rescan = 1'b1;
          end
        end
        MODE_STRING: begin
          unique case (s_in.sub)
            ST_BODY: begin
              if (c == "\"") begin
                r = emit_tok(r, KIND_STRING, s_in.tok_begin, {1'b0, len} + (OB+1)'(1),
                             s_in.esc);
                r.s.mode = MODE_IDLE;
              end else if (c == "\\") begin
                r.s.esc = 1'b1;
                r.s.sub = ST_ESC;
              end else if (c < 8'h20) r = fail_tok(r, len);
              else if (c >= 8'h80) begin
                if (c >= 8'hC2 && c <= 8'hDF) begin
                  r.s.u_len = 3'd2;
                  r.s.u_rem = 2'd1;
                  r.s.cp = {16'd0, c[4:0]};
                  r.s.sub = ST_UTF8;
                end else if (c >= 8'hE0 && c <= 8'hEF) begin
                  r.s.u_len = 3'd3;
                  r.s.u_rem = 2'd2;
                  r.s.cp = {17'd0, c[3:0]};
                  r.s.sub = ST_UTF8;
                end else if (c >= 8'hF0 && c <= 8'hF4) begin
                  r.s.u_len = 3'd4;
                  r.s.u_rem = 2'd3;
                  r.s.cp = {18'd0, c[2:0]};
                  r.s.sub = ST_UTF8;
                end else r = fail_tok(r, len);
              end
            end
            ST_ESC: begin
              if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" || c == "n" ||
                  c == "r" || c == "t") r.s.sub = ST_BODY;
              else if (c == "u") begin
                r.s.hex_cnt = 3'd0;
                r.s.sub = ST_HEX;
              end else r = fail_tok(r, len);
            end
            ST_HEX: begin
              if (!hexd) r = fail_tok(r, len - {{(OB-3){1'b0}}, s_in.hex_cnt} - OB'(1));
              else begin
                r.s.hex_cnt = s_in.hex_cnt + 3'd1;
                if (s_in.hex_cnt >= 3'd3) r.s.sub = ST_BODY;
              end
            end
            default: begin
              if (c[7:6] != 2'b10 || s_in.u_rem == 2'd0) r = fail_tok(r, lead - s_in.tok_begin);
              else begin
                r.s.cp = cpn;
                r.s.u_rem = s_in.u_rem - 2'd1;
                if (s_in.u_rem == 2'd1) begin
                  if ((s_in.u_len == 3'd3 && (cpn < 21'h800 ||
                       (cpn >= 21'hD800 && cpn <= 21'hDFFF))) ||
                      (s_in.u_len == 3'd4 && (cpn < 21'h10000 || cpn > 21'h10FFFF)))
                    r = fail_tok(r, lead - s_in.tok_begin);
                  else r.s.sub = ST_BODY;
                end
              end
            end
          endcase
        end
        default: rescan = 1'b1;
      endcase
    end
    if (rescan && !r.s.stopped) begin
      r.s.tok_begin = off;
      if (c >= "1" && c <= "9") begin
        r.s.mode = MODE_NUMBER;
        r.s.sub = NM_INT;
      end else begin
        unique case (c)
          8'h20, 8'h09, 8'h0D, 8'h0A: ;
          8'h00: begin
            r = emit_tok(r, KIND_END, off, '0, 1'b0);
            r.s.stopped = 1'b1;
          end
          "/": r.s.mode = MODE_SLASH;
          ",": r = emit_tok(r, KIND_COMMA, off, (OB+1)'(1), 1'b0);
          ":": r = emit_tok(r, KIND_COLON, off, (OB+1)'(1), 1'b0);
          "{": r = emit_tok(r, KIND_LCURLY, off, (OB+1)'(1), 1'b0);
          "}": r = emit_tok(r, KIND_RCURLY, off, (OB+1)'(1), 1'b0);
          "[": r = emit_tok(r, KIND_LBRACK, off, (OB+1)'(1), 1'b0);
          "]": r = emit_tok(r, KIND_RBRACK, off, (OB+1)'(1), 1'b0);
          "\"": begin
            r.s.mode = MODE_STRING;
            r.s.sub = ST_BODY;
            r.s.esc = 1'b0;
          end
          "t", "f", "n": begin
            r.s.mode = MODE_KEYWORD;
            r.s.kw_id = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
            r.s.kw_mm = 1'b0;
          end
          "-": begin
            r.s.mode = MODE_NUMBER;
            r.s.sub = NM_SIGN;
          end
          "0": begin
            r.s.mode = MODE_NUMBER;
            r.s.sub = NM_ZERO;
          end
          default: begin
            r.s.tok_begin = off;
            r = fail_tok(r, OB'(1));
          end
        endcase
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/jtok_if.sv */
// valid/ready channel interfaces for bytes in and tokens out
// depends on jtok_pkg
interface jtok_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface jtok_out_if (input logic clk);
  logic                     valid;
  logic                     ready;
  logic [3:0]               token_kind;
  logic [jtok_pkg::OB-1:0]  token_start;
  logic [jtok_pkg::OB:0]    token_length;
  logic                     string_escaped;
  logic                     run_end;
  modport source (output valid, token_kind, token_start, token_length, string_escaped,
                  run_end, input ready);
  modport sink (input valid, token_kind, token_start, token_length, string_escaped,
                run_end, output ready);
endinterface

/* hw/rtl/jtok_scan.sv */
// scanner state register and per-byte token logic
// depends on jtok_pkg
module jtok_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        text_byte,
  input  logic              end_of_text,
  output jtok_pkg::push_t   push
);
  jtok_pkg::scan_st_t st_r, st_nxt, mid;
  jtok_pkg::feed_t    f1, f2;
  jtok_pkg::tok_t [3:0] all;
  logic [2:0]         cnt;
  logic [jtok_pkg::OB-1:0] nxt_off;

  always_comb begin
    nxt_off = st_r.idx + jtok_pkg::OB'(1);
    f1 = jtok_pkg::feed(st_r, text_byte, st_r.idx);
    mid = f1.s;
    mid.idx = nxt_off;
    f2 = jtok_pkg::feed(mid, 8'h00, nxt_off);
    all = '0;
    cnt = 3'd0;
    push = '0;
    st_nxt = st_r;
    if (!st_r.stopped) begin
      if (st_r.idx == jtok_pkg::OFF_MAX) begin
        all[0].kind = jtok_pkg::KIND_ERROR;
        all[0].start = jtok_pkg::OFF_MAX;
        cnt = 3'd1;
        st_nxt.stopped = 1'b1;
      end else begin
        for (int k = 0; k < 2; k++) begin
          if (k < int'(f1.n)) begin
            all[cnt[1:0]] = f1.tok[k];
            cnt = cnt + 3'd1;
          end
        end
        if (end_of_text) begin
          for (int k = 0; k < 2; k++) begin
            if (k < int'(f2.n) && cnt < 3'd3) begin
              all[cnt[1:0]] = f2.tok[k];
              cnt = cnt + 3'd1;
            end
          end
        end
        st_nxt = mid;
      end
    end
    if (cnt != 3'd0) all[cnt[1:0] - 2'd1].run_end = 1'b1;
    if (take) begin
      push.n = cnt[1:0];
      push.tok = all[2:0];
    end
    if (end_of_text) st_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= '0;
    else if (take) st_r <= st_nxt;
  end
endmodule

/* hw/rtl/jtok_fifo.sv */
// token queue: takes up to three tokens a cycle, gives one from a registered output
// depends on jtok_pkg and assert_macros.svh
`include "assert_macros.svh"
module jtok_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  jtok_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output jtok_pkg::tok_t    out_tok
);
  jtok_pkg::tok_t mem_r [jtok_pkg::FIFO_DEPTH];
  jtok_pkg::tok_t out_tok_r;
  logic [jtok_pkg::FIFO_AW-1:0] wr_r, rd_r;
  logic [jtok_pkg::FIFO_AW:0]   cnt_r;
  logic out_valid_r;
  logic pop;
  logic load;

  assign room = cnt_r <= (jtok_pkg::FIFO_AW+1)'(jtok_pkg::FIFO_DEPTH - 3);
  assign out_valid = out_valid_r;
  assign out_tok = out_tok_r;
  assign pop = out_valid_r && out_ready;
  // refill the output register when it is empty or being taken
  assign load = (cnt_r != '0) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (k < int'(push.n)) mem_r[wr_r + jtok_pkg::FIFO_AW'(k)] <= push.tok[k];
    end
    if (load) out_tok_r <= mem_r[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_r <= wr_r + jtok_pkg::FIFO_AW'(push.n);
      rd_r <= rd_r + jtok_pkg::FIFO_AW'(load);
      cnt_r <= cnt_r + (jtok_pkg::FIFO_AW+1)'(push.n) - (jtok_pkg::FIFO_AW+1)'(load);
      if (load) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_cnt_max, clk, rst_n, cnt_r <= (jtok_pkg::FIFO_AW+1)'(jtok_pkg::FIFO_DEPTH))
  `ASSERT_ALWAYS(a_push_room, clk, rst_n, push.n == 2'd0 || room)
  `ASSERT_NEXT(a_load_only, clk, rst_n, load && push.n == 2'd0, cnt_r == $past(cnt_r) - 1'b1)
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && out_tok_r == $past(out_tok_r))
endmodule

/* hw/rtl/json_byte_tokenizer.sv */
// json tokenizer: one byte per transaction in, up to three tokens per byte out
// tokens are written into the queue when the byte is taken and then pass to the
// output register, from which the consumer takes them
// throughput: one byte per cycle while the 8-entry token queue has room for 3
// tokens; output drains one token per cycle while out_tx.ready is high
// reset: synchronous active-low rst_n clears scanner state and queue pointers
module json_byte_tokenizer (
  input logic            clk,
  input logic            rst_n,
  jtok_in_if.sink        in_tx,
  jtok_out_if.source     out_tx
);
  jtok_pkg::push_t push;
  jtok_pkg::tok_t  tok;
  logic            room;
  logic            take;

  // accept bytes whenever the queue can hold the worst-case burst of tokens
  assign in_tx.ready = room;
  assign take = in_tx.valid && room;

  // scanner: byte, plus the virtual nul after the last byte, in one step
  // end_of_text also returns the scanner to reset state after its tokens
  jtok_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .text_byte   (in_tx.text_byte),
    .end_of_text (in_tx.end_of_text),
    .push        (push)
  );

  // queue decouples token bursts from the consumer
  jtok_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tx.valid),
    .out_ready (out_tx.ready),
    .out_tok   (tok)
  );

  assign out_tx.token_kind = tok.kind;
  assign out_tx.token_start = tok.start;
  assign out_tx.token_length = tok.len;
  assign out_tx.string_escaped = tok.esc;
  assign out_tx.run_end = tok.run_end;
endmodule
